// ===== sv/stbs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stbs_pkg: shared types and constants for the slot table
// Record layout, table sizing, request and status codes.
// ----------------------------------------------------------------------------
package stbs_pkg;

  localparam int MAX_SLOTS = 16;
  localparam int IDX_W     = $clog2(MAX_SLOTS);
  localparam int CNT_W     = $clog2(MAX_SLOTS + 1);
  // walk pointers reach past the count by up to two
  localparam int PTR_W     = CNT_W + 1;
  localparam int ID_W      = 5;

  typedef struct packed {
    logic [ID_W-1:0] id;
    logic [4:0]      hr;
    logic [5:0]      st;
    logic [5:0]      en;
    logic [7:0]      mn;
    logic [7:0]      mx;
    logic [15:0]     tag;
    logic            bk;
  } rec_t;

  typedef enum logic [1:0] {
    REQ_ADD  = 2'd0,
    REQ_BOOK = 2'd1,
    REQ_SORT = 2'd2,
    REQ_READ = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BOOKED   = 3'd1,
    ST_NO_SLOT  = 3'd2,
    ST_FULL     = 3'd3,
    ST_EMPTY    = 3'd4
  } status_t;

endpackage

// ===== sv/stbs_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stbs_ram: slot record storage
// One write port, two registered read ports.
// ----------------------------------------------------------------------------
module stbs_ram (
  input  logic                      clk,
  input  logic                      we,
  input  logic [stbs_pkg::IDX_W-1:0] waddr,
  input  stbs_pkg::rec_t            wdata,
  input  logic [stbs_pkg::IDX_W-1:0] raddr_a,
  input  logic [stbs_pkg::IDX_W-1:0] raddr_b,
  output stbs_pkg::rec_t            rdata_a,
  output stbs_pkg::rec_t            rdata_b
);

  stbs_pkg::rec_t mem [stbs_pkg::MAX_SLOTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ===== sv/slot_table_book_and_sort.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slot_table_book_and_sort: time-slot table with add, book, sort and read
// Sequencer over a two-read-port record memory and one hour comparator.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken when start is high and busy is low. Fields not used
//   by the request type are ignored. Exactly one result follows each
//   request: done pulses for one cycle with status and the result fields;
//   fields a request does not define read as zero. The receiver cannot
//   stall, so the result must be captured in the done cycle.
// Sequence (request to done):
//   add, or a read of an empty position: result straight from S_IDLE.
//   read: S_RD_RD, then S_RD_OUT.
//   book: S_BK_RD and S_BK_CHK for each record walked, stopping at the
//   matching id, or in S_BK_RD past the last record when none matches.
//   sort: for each pair S_SR_RD and S_SR_CMP, plus S_SR_WR when swapped;
//   an outer step passes through S_SR_RD alone. The single memory write
//   port makes a swap take two writes, in S_SR_CMP and S_SR_WR.
// A new request may be issued in the done cycle.
// Reset clears the record count and the sequencer; record contents are not
// cleared and are only ever read at positions below the count.
// ----------------------------------------------------------------------------
module slot_table_book_and_sort (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  req_type,
  input  logic [4:0]  hour,
  input  logic [5:0]  start_minute,
  input  logic [5:0]  end_minute,
  input  logic [7:0]  min_duration,
  input  logic [7:0]  max_duration,
  input  logic [4:0]  target_id,
  input  logic [15:0] visitor_tag,
  input  logic [3:0]  read_position,
  output logic        done,
  output logic [2:0]  status,
  output logic [4:0]  slot_id,
  output logic [4:0]  out_hour,
  output logic [5:0]  out_start,
  output logic [5:0]  out_end,
  output logic [7:0]  out_min,
  output logic [7:0]  out_max,
  output logic [15:0] out_tag,
  output logic        out_booked
);

  typedef enum logic [2:0] {
    S_IDLE, S_BK_RD, S_BK_CHK, S_RD_RD, S_RD_OUT, S_SR_RD, S_SR_CMP, S_SR_WR
  } state_t;

  typedef struct packed {
    stbs_pkg::status_t st;
    stbs_pkg::rec_t    rec;
  } res_t;

  localparam int PW = stbs_pkg::PTR_W;
  localparam int IW = stbs_pkg::IDX_W;

  state_t                      state;
  logic [stbs_pkg::CNT_W-1:0]  count;
  logic [PW-1:0]               i, j;
  logic [4:0]                  want_id;
  logic [15:0]                 want_tag;
  stbs_pkg::rec_t              rec_a;

  logic                        accept;
  logic [PW-1:0]               cnt_ext;
  logic                        full;
  stbs_pkg::rec_t              new_rec;
  stbs_pkg::rec_t              rd_a, rd_b;
  logic                        we;
  logic [IW-1:0]               waddr;
  stbs_pkg::rec_t              wdata;
  logic                        res_fire;
  res_t                        res;

  assign busy    = (state != S_IDLE);
  assign accept  = start && !busy;
  assign cnt_ext = PW'(count);
  assign full    = (count == stbs_pkg::CNT_W'(stbs_pkg::MAX_SLOTS));

  always_comb begin
    new_rec     = '0;
    new_rec.id  = stbs_pkg::ID_W'(count + 1'b1);
    new_rec.hr  = hour;
    new_rec.st  = start_minute;
    new_rec.en  = end_minute;
    new_rec.mn  = min_duration;
    new_rec.mx  = max_duration;
  end

  stbs_ram u_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (i[IW-1:0]),
    .raddr_b (j[IW-1:0]),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  // write port and result selection
  always_comb begin
    we       = 1'b0;
    waddr    = i[IW-1:0];
    wdata    = rd_b;
    res_fire = 1'b0;
    res      = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (stbs_pkg::req_t'(req_type))
            stbs_pkg::REQ_ADD: begin
              res_fire = 1'b1;
              if (full) begin
                res.st = stbs_pkg::ST_FULL;
              end else begin
                we         = 1'b1;
                waddr      = count[IW-1:0];
                wdata      = new_rec;
                res.rec.id = new_rec.id;
              end
            end
            stbs_pkg::REQ_READ: begin
              if (PW'(read_position) >= cnt_ext) begin
                res_fire = 1'b1;
                res.st   = stbs_pkg::ST_EMPTY;
              end
            end
            default: ;
          endcase
        end
      end
      S_BK_RD: begin
        if (i >= cnt_ext) begin
          res_fire = 1'b1;
          res.st   = stbs_pkg::ST_NO_SLOT;
        end
      end
      S_BK_CHK: begin
        if (rd_a.id == want_id) begin
          res_fire = 1'b1;
          if (rd_a.bk) begin
            res.st = stbs_pkg::ST_BOOKED;
          end else begin
            we        = 1'b1;
            wdata     = rd_a;
            wdata.tag = want_tag;
            wdata.bk  = 1'b1;
          end
        end
      end
      S_RD_OUT: begin
        res_fire = 1'b1;
        res.rec  = rd_a;
      end
      S_SR_RD: begin
        if (j >= cnt_ext && (i + PW'(2)) >= cnt_ext) begin
          res_fire = 1'b1;
        end
      end
      S_SR_CMP: begin
        // first half of a swap: lower position takes the earlier record
        if (rd_a.hr > rd_b.hr) begin
          we = 1'b1;
        end
      end
      S_SR_WR: begin
        we    = 1'b1;
        waddr = j[IW-1:0];
        wdata = rec_a;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= res_fire;
      if (res_fire) begin
        status     <= res.st;
        slot_id    <= res.rec.id;
        out_hour   <= res.rec.hr;
        out_start  <= res.rec.st;
        out_end    <= res.rec.en;
        out_min    <= res.rec.mn;
        out_max    <= res.rec.mx;
        out_tag    <= res.rec.tag;
        out_booked <= res.rec.bk;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (stbs_pkg::req_t'(req_type))
              stbs_pkg::REQ_ADD: begin
                if (!full) begin
                  count <= count + 1'b1;
                end
              end
              stbs_pkg::REQ_BOOK: begin
                i        <= '0;
                want_id  <= target_id;
                want_tag <= visitor_tag;
                state    <= S_BK_RD;
              end
              stbs_pkg::REQ_SORT: begin
                i     <= '0;
                j     <= PW'(1);
                state <= S_SR_RD;
              end
              stbs_pkg::REQ_READ: begin
                i <= PW'(read_position);
                if (PW'(read_position) < cnt_ext) begin
                  state <= S_RD_RD;
                end
              end
              default: ;
            endcase
          end
        end
        S_BK_RD: begin
          state <= (i >= cnt_ext) ? S_IDLE : S_BK_CHK;
        end
        S_BK_CHK: begin
          if (rd_a.id == want_id) begin
            state <= S_IDLE;
          end else begin
            i     <= i + 1'b1;
            state <= S_BK_RD;
          end
        end
        S_RD_RD: begin
          state <= S_RD_OUT;
        end
        S_RD_OUT: begin
          state <= S_IDLE;
        end
        S_SR_RD: begin
          if (j >= cnt_ext) begin
            if ((i + PW'(2)) >= cnt_ext) begin
              state <= S_IDLE;
            end else begin
              i <= i + 1'b1;
              j <= i + PW'(2);
            end
          end else begin
            state <= S_SR_CMP;
          end
        end
        S_SR_CMP: begin
          if (rd_a.hr > rd_b.hr) begin
            rec_a <= rd_a;
            state <= S_SR_WR;
          end else begin
            j     <= j + 1'b1;
            state <= S_SR_RD;
          end
        end
        S_SR_WR: begin
          j     <= j + 1'b1;
          state <= S_SR_RD;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench for slot_table_book_and_sort
// Issues add, book, sort and read requests with random gaps between them,
// keeps its own copy of the slot table, and checks every result
// field by field against the answer worked out from that copy.
// ----------------------------------------------------------------------------
module tb;

  typedef struct packed {
    stbs_pkg::req_t kind;
    logic [4:0]     hour;
    logic [5:0]     start_minute;
    logic [5:0]     end_minute;
    logic [7:0]     min_duration;
    logic [7:0]     max_duration;
    logic [4:0]     target_id;
    logic [15:0]    visitor_tag;
    logic [3:0]     read_position;
  } slot_req_t;

  typedef struct packed {
    stbs_pkg::status_t status;
    logic [4:0]        slot_id;
    logic [4:0]        out_hour;
    logic [5:0]        out_start;
    logic [5:0]        out_end;
    logic [7:0]        out_min;
    logic [7:0]        out_max;
    logic [15:0]       out_tag;
    logic              out_booked;
  } slot_result_t;

  localparam int TOTAL_REQS = 1450;
  localparam int TAIL_CYCLES = 400;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [1:0]  req_type = stbs_pkg::REQ_ADD;
  logic [4:0]  hour = '0;
  logic [5:0]  start_minute = '0;
  logic [5:0]  end_minute = '0;
  logic [7:0]  min_duration = '0;
  logic [7:0]  max_duration = '0;
  logic [4:0]  target_id = '0;
  logic [15:0] visitor_tag = '0;
  logic [3:0]  read_position = '0;
  logic        busy;
  logic        done;
  logic [2:0]  status;
  logic [4:0]  slot_id;
  logic [4:0]  out_hour;
  logic [5:0]  out_start;
  logic [5:0]  out_end;
  logic [7:0]  out_min;
  logic [7:0]  out_max;
  logic [15:0] out_tag;
  logic        out_booked;

  slot_table_book_and_sort uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .req_type(req_type), .hour(hour), .start_minute(start_minute),
    .end_minute(end_minute), .min_duration(min_duration),
    .max_duration(max_duration), .target_id(target_id),
    .visitor_tag(visitor_tag), .read_position(read_position),
    .done(done), .status(status), .slot_id(slot_id), .out_hour(out_hour),
    .out_start(out_start), .out_end(out_end), .out_min(out_min),
    .out_max(out_max), .out_tag(out_tag), .out_booked(out_booked)
  );

  stbs_pkg::rec_t mirror_recs [stbs_pkg::MAX_SLOTS];
  int             mirror_count = 0;
  slot_result_t   awaited_results [$];
  int             mismatches = 0;
  int             reqs_sent = 0;
  bit             steady_feed = 1'b0;

  initial begin
    forever #1 clk = ~clk;
  end

  // Applies one request to the mirrored table and returns the answer.
  function automatic slot_result_t apply_request(slot_req_t r);
    slot_result_t   res;
    stbs_pkg::rec_t tmp;
    res = '0;
    case (r.kind)
      stbs_pkg::REQ_ADD: begin
        if (mirror_count >= stbs_pkg::MAX_SLOTS) begin
          res.status = stbs_pkg::ST_FULL;
        end else begin
          tmp = '0;
          tmp.id = 5'(mirror_count + 1);
          tmp.hr = r.hour;
          tmp.st = r.start_minute;
          tmp.en = r.end_minute;
          tmp.mn = r.min_duration;
          tmp.mx = r.max_duration;
          mirror_recs[mirror_count] = tmp;
          mirror_count++;
          res.status = stbs_pkg::ST_OK;
          res.slot_id = tmp.id;
        end
      end
      stbs_pkg::REQ_BOOK: begin
        res.status = stbs_pkg::ST_NO_SLOT;
        // ids are unique, so at most one record matches
        for (int i = 0; i < mirror_count; i++) begin
          if (mirror_recs[i].id == r.target_id) begin
            if (mirror_recs[i].bk) begin
              res.status = stbs_pkg::ST_BOOKED;
            end else begin
              mirror_recs[i].tag = r.visitor_tag;
              mirror_recs[i].bk = 1'b1;
              res.status = stbs_pkg::ST_OK;
            end
          end
        end
      end
      stbs_pkg::REQ_SORT: begin
        for (int i = 0; i < mirror_count; i++) begin
          for (int j = i + 1; j < mirror_count; j++) begin
            if (mirror_recs[i].hr > mirror_recs[j].hr) begin
              tmp = mirror_recs[i];
              mirror_recs[i] = mirror_recs[j];
              mirror_recs[j] = tmp;
            end
          end
        end
        res.status = stbs_pkg::ST_OK;
      end
      default: begin
        if (r.read_position >= mirror_count) begin
          res.status = stbs_pkg::ST_EMPTY;
        end else begin
          tmp = mirror_recs[r.read_position];
          res.status = stbs_pkg::ST_OK;
          res.slot_id = tmp.id;
          res.out_hour = tmp.hr;
          res.out_start = tmp.st;
          res.out_end = tmp.en;
          res.out_min = tmp.mn;
          res.out_max = tmp.mx;
          res.out_tag = tmp.tag;
          res.out_booked = tmp.bk;
        end
      end
    endcase
    return res;
  endfunction

  // All fields random; the block ignores those the request does not use.
  function automatic slot_req_t rand_item(stbs_pkg::req_t kind);
    slot_req_t r;
    int        roll;
    r.kind = kind;
    r.hour = 5'($urandom_range(0, 23));
    r.start_minute = 6'($urandom_range(0, 59));
    r.end_minute = 6'($urandom_range(0, 59));
    r.min_duration = 8'($urandom_range(0, 255));
    r.max_duration = 8'($urandom_range(0, 255));
    if (mirror_count > 0 && $urandom_range(0, 3) != 0)
      r.target_id = 5'($urandom_range(1, mirror_count));
    else
      r.target_id = 5'($urandom_range(0, 16));
    roll = $urandom_range(0, 9);
    if (roll == 0)
      r.visitor_tag = 16'h0000;
    else if (roll == 1)
      r.visitor_tag = 16'hffff;
    else
      r.visitor_tag = 16'($urandom_range(0, 65535));
    r.read_position = 4'($urandom_range(0, 15));
    return r;
  endfunction

  // Leaves start high on return so a back-to-back request needs no toggle.
  task automatic send_req(input slot_req_t r);
    int gap;
    if (reqs_sent % 40 == 0)
      steady_feed = ($urandom_range(0, 3) == 0);
    gap = steady_feed ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    req_type <= r.kind;
    hour <= r.hour;
    start_minute <= r.start_minute;
    end_minute <= r.end_minute;
    min_duration <= r.min_duration;
    max_duration <= r.max_duration;
    target_id <= r.target_id;
    visitor_tag <= r.visitor_tag;
    read_position <= r.read_position;
    @(posedge clk);
    while (busy) @(posedge clk);
    awaited_results.push_back(apply_request(r));
    reqs_sent++;
  endtask

  task automatic do_add(input int h, input int s, input int e, input int mn, input int mx);
    slot_req_t r;
    r = rand_item(stbs_pkg::REQ_ADD);
    r.hour = 5'(h);
    r.start_minute = 6'(s);
    r.end_minute = 6'(e);
    r.min_duration = 8'(mn);
    r.max_duration = 8'(mx);
    send_req(r);
  endtask

  task automatic do_book(input int id, input int tag);
    slot_req_t r;
    r = rand_item(stbs_pkg::REQ_BOOK);
    r.target_id = 5'(id);
    r.visitor_tag = 16'(tag);
    send_req(r);
  endtask

  task automatic do_read(input int pos);
    slot_req_t r;
    r = rand_item(stbs_pkg::REQ_READ);
    r.read_position = 4'(pos);
    send_req(r);
  endtask

  task automatic test_empty_table();
    do_read(0);
    do_book(1, 16'h1234);
    do_book(0, 16'h0001);
    send_req(rand_item(stbs_pkg::REQ_SORT));
  endtask

  task automatic test_add_book_sort();
    do_add(23, 59, 0, 255, 0);
    do_add(0, 0, 59, 0, 255);
    do_add(23, 4, 27, 170, 85);
    do_book(1, 0);          // zero tag still books
    do_book(1, 16'hffff);   // already booked, tag kept
    do_book(2, 16'hffff);
    do_book(0, 16'h5a5a);
    do_book(16, 16'ha5a5);
    send_req(rand_item(stbs_pkg::REQ_SORT));
    do_read(0);
    do_read(1);
    do_read(2);
    do_read(3);
    do_read(15);
  endtask

  // Sorts interleave with adds while the table grows, so orders vary.
  task automatic test_grow_table();
    int             roll;
    stbs_pkg::req_t kind;
    while (mirror_count < stbs_pkg::MAX_SLOTS) begin
      roll = $urandom_range(0, 99);
      if (roll < 4) kind = stbs_pkg::REQ_ADD;
      else if (roll < 16) kind = stbs_pkg::REQ_SORT;
      else if (roll < 46) kind = stbs_pkg::REQ_BOOK;
      else kind = stbs_pkg::REQ_READ;
      send_req(rand_item(kind));
    end
  endtask

  task automatic test_table_full();
    do_add(12, 30, 45, 60, 90);
    do_add(23, 59, 59, 255, 255);
    do_read(15);
    do_book(16, 16'hbeef);
  endtask

  task automatic test_random_mix();
    int             roll;
    stbs_pkg::req_t kind;
    while (reqs_sent < TOTAL_REQS) begin
      roll = $urandom_range(0, 99);
      if (roll < 6) kind = stbs_pkg::REQ_ADD;
      else if (roll < 14) kind = stbs_pkg::REQ_SORT;
      else if (roll < 44) kind = stbs_pkg::REQ_BOOK;
      else kind = stbs_pkg::REQ_READ;
      send_req(rand_item(kind));
    end
  endtask

  always @(posedge clk) begin : result_check
    slot_result_t got;
    slot_result_t want;
    if (!rst && done) begin
      got.status = stbs_pkg::status_t'(status);
      got.slot_id = slot_id;
      got.out_hour = out_hour;
      got.out_start = out_start;
      got.out_end = out_end;
      got.out_min = out_min;
      got.out_max = out_max;
      got.out_tag = out_tag;
      got.out_booked = out_booked;
      if (awaited_results.size() == 0) begin
        if (mismatches < 10)
          $display("%0t: result with no request pending: status=%0d id=%0d",
                   $realtime, status, slot_id);
        mismatches++;
      end else begin
        want = awaited_results.pop_front();
        if (got !== want) begin
          if (mismatches < 10) begin
            $display({"%0t: mismatch exp st=%0d id=%0d hr=%0d s=%0d e=%0d",
                      " mn=%0d mx=%0d tag=%h bk=%0d"},
                     $realtime, want.status, want.slot_id, want.out_hour,
                     want.out_start, want.out_end, want.out_min, want.out_max,
                     want.out_tag, want.out_booked);
            $display({"%0t:          got st=%0d id=%0d hr=%0d s=%0d e=%0d",
                      " mn=%0d mx=%0d tag=%h bk=%0d"},
                     $realtime, got.status, got.slot_id, got.out_hour,
                     got.out_start, got.out_end, got.out_min, got.out_max,
                     got.out_tag, got.out_booked);
          end
          mismatches++;
        end
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_empty_table();
    test_add_book_sort();
    test_grow_table();
    test_table_full();
    test_random_mix();
    start <= 1'b0;
    while (awaited_results.size() > 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  // worst case is roughly 1450 full-table sorts with maximal gaps
  initial begin
    #5000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
